### rtl/core/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Plain invariant checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`endif

### rtl/core/cstok_pkg.sv
// Package for the C source tokenizer: token kinds, diagnostics, result bundle.
// No dependencies.
`default_nettype none
package cstok_pkg;
    localparam int KeywordCount = 23;
    localparam int LengthLimit  = 255;
    localparam int LenW         = 8;
    localparam logic [23:0] LineTop = 24'hFFFFFF;
    localparam logic signed [15:0] BalTop = 16'sd32767;

    localparam logic [2:0] K_KEYWORD = 3'd0;
    localparam logic [2:0] K_IDENT   = 3'd1;
    localparam logic [2:0] K_CONST   = 3'd2;
    localparam logic [2:0] K_OPER    = 3'd3;
    localparam logic [2:0] K_SPECIAL = 3'd4;
    localparam logic [2:0] K_UNKNOWN = 3'd5;
    localparam logic [2:0] K_DIAG    = 3'd6;
    localparam logic [2:0] K_END     = 3'd7;

    localparam logic [3:0] D_NONE    = 4'd0;
    localparam logic [3:0] D_NO_RPAR = 4'd1;
    localparam logic [3:0] D_NO_LPAR = 4'd2;
    localparam logic [3:0] D_NO_RBRC = 4'd3;
    localparam logic [3:0] D_NO_LBRC = 4'd4;
    localparam logic [3:0] D_NO_DQ   = 4'd5;
    localparam logic [3:0] D_NO_SQ   = 4'd6;
    localparam logic [3:0] D_RADIX   = 4'd6;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [4:0]  keyword_index;
        logic [3:0]  diagnostic;
        logic [23:0] line_number;
        logic [31:0] start_offset;
        logic [7:0]  lexeme_length;
    } result_t;

    // results of one item: up to three, count and payloads
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
        result_t    r2;
    } group_t;

    function automatic logic [3:0] kw_len(input logic [4:0] idx);
        case (idx)
            5'd0, 5'd6: kw_len = 4'd3;
            5'd3, 5'd7: kw_len = 4'd2;
            5'd4, 5'd10, 5'd12, 5'd14: kw_len = 4'd4;
            5'd1, 5'd5, 5'd8, 5'd16, 5'd22: kw_len = 4'd5;
            5'd2, 5'd11, 5'd13, 5'd17, 5'd18, 5'd19, 5'd21: kw_len = 4'd6;
            5'd15, 5'd20: kw_len = 4'd7;
            5'd9: kw_len = 4'd8;
            default: kw_len = 4'd0;
        endcase
    endfunction

    // character at position pos of keyword idx (left aligned)
    function automatic logic [7:0] kw_at(input logic [4:0] idx, input logic [7:0] pos);
        logic [63:0] w;
        logic [3:0]  n;
        begin
            case (idx)
                5'd0:  w = "int";
                5'd1:  w = "float";
                5'd2:  w = "return";
                5'd3:  w = "if";
                5'd4:  w = "else";
                5'd5:  w = "while";
                5'd6:  w = "for";
                5'd7:  w = "do";
                5'd8:  w = "break";
                5'd9:  w = "continue";
                5'd10: w = "char";
                5'd11: w = "double";
                5'd12: w = "void";
                5'd13: w = "switch";
                5'd14: w = "case";
                5'd15: w = "default";
                5'd16: w = "const";
                5'd17: w = "static";
                5'd18: w = "sizeof";
                5'd19: w = "struct";
                5'd20: w = "else if";
                5'd21: w = "printf";
                5'd22: w = "scanf";
                default: w = '0;
            endcase
            n = kw_len(idx);
            kw_at = 8'd0;
            for (int k = 0; k < 8; k++)
            begin
                if (pos == 8'(k) && 4'(k) < n)
                    kw_at = w[8*(32'(n) - 1 - k) +: 8];
            end
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0" && c <= "9");
    endfunction
    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_op(input logic [7:0] c);
        is_op = (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%")
             || (c == "=") || (c == "!") || (c == "|") || (c == "&") || (c == "<")
             || (c == ">") || (c == "^");
    endfunction
    function automatic logic is_special(input logic [7:0] c);
        is_special = (c == ",") || (c == ";") || (c == "{") || (c == "}") || (c == "(")
                  || (c == ")") || (c == "[") || (c == "]") || (c == ":");
    endfunction
endpackage
`default_nettype wire

### rtl/core/cstok_front.sv
// Front end: accepts bytes, runs the lexer state, builds the results of each item.
// Depends on cstok_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cstok_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_go,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_end,
    output cstok_pkg::group_t      grp
);
    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_ZERO, M_OPER, M_SLASH, M_STR, M_CHR, M_HASH, M_LCOM,
        M_BCOM, M_BSTAR
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [7:0]         len_reg, len_next;
    logic [22:0]        alive_reg, alive_next;
    logic [2:0]         num_reg, num_next;
    logic [4:0]         rad_reg, rad_next;
    logic [31:0]        start_reg, start_next;
    logic [31:0]        off_reg;
    logic [23:0]        lines_reg, lines_next;
    logic signed [15:0] par_reg, par_next, brc_reg, brc_next;

    cstok_pkg::group_t  g;
    logic [23:0]        cur_ln;

    function automatic logic [7:0] grow(input logic [7:0] l);
        grow = (l < 8'(cstok_pkg::LengthLimit)) ? l + 8'd1 : l;
    endfunction
    function automatic logic signed [15:0] bal(input logic signed [15:0] b,
                                               input logic up);
        if (up)
            bal = (b == cstok_pkg::BalTop) ? b : b + 16'sd1;
        else
            bal = (b == -cstok_pkg::BalTop) ? b : b - 16'sd1;
    endfunction

    always_comb
    begin
        logic [7:0]  c;
        logic        redo;
        logic [23:0] ln_used;
        logic        hit;
        logic [1:0]  kd;
        logic        ok;
        cstok_pkg::result_t r;
        c = in_byte;
        mode_next  = mode_reg;
        len_next   = len_reg;
        alive_next = alive_reg;
        num_next   = num_reg;
        rad_next   = rad_reg;
        start_next = start_reg;
        lines_next = lines_reg;
        par_next   = par_reg;
        brc_next   = brc_reg;
        g          = '0;
        redo       = 1'b0;
        cur_ln     = (lines_reg >= cstok_pkg::LineTop) ? cstok_pkg::LineTop : lines_reg + 24'd1;
        ln_used    = cur_ln;
        r          = '0;
        hit        = 1'b0;
        kd         = 2'd0;
        ok         = 1'b0;

        // finishing a pending token at end of text
        if (in_end)
        begin
            r.start_offset  = start_reg;
            r.lexeme_length = len_reg;
            r.line_number   = cur_ln;
            case (mode_reg)
                M_WORD, M_ZERO, M_OPER, M_SLASH, M_STR, M_CHR:
                begin
                    g.count = 2'd1;
                end
                default: g.count = 2'd0;
            endcase
        end

        if (!in_end)
        begin
            case (mode_reg)
                M_WORD:
                begin
                    if (cstok_pkg::is_digit(c) || cstok_pkg::is_letter(c) || c == "_"
                        || c == ".")
                    begin
                        for (int i = 0; i < cstok_pkg::KeywordCount; i++)
                        begin
                            if (cstok_pkg::kw_at(5'(i), len_reg) != c
                                || {4'd0, cstok_pkg::kw_len(5'(i))} <= len_reg)
                                alive_next[i] = 1'b0;
                        end
                        if (num_reg[2])
                            num_next[0] = 1'b1;
                        if (c == ".")
                            num_next[1] = 1'b1;
                        else if (cstok_pkg::is_digit(c))
                            num_next = num_next;
                        else if ((c == "f" || c == "F") && num_reg[1])
                            num_next[2] = 1'b1;
                        else
                            num_next[0] = 1'b1;
                        len_next = grow(len_reg);
                    end
                    else
                    begin
                        g.count = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_ZERO:
                begin
                    if (cstok_pkg::is_digit(c) || cstok_pkg::is_letter(c))
                    begin
                        kd = rad_reg[1:0];
                        if (kd == 2'd0 && c == "x")
                            rad_next[0] = 1'b1;
                        else if (kd == 2'd0 && c == "b")
                            rad_next[1] = 1'b1;
                        else
                        begin
                            if (kd == 2'd0)
                            begin
                                kd = 2'd3;
                                rad_next[1:0] = 2'd3;
                            end
                            if (kd == 2'd1)
                                ok = cstok_pkg::is_digit(c) || (c >= "a" && c <= "f")
                                  || (c >= "A" && c <= "F");
                            else if (kd == 2'd2)
                                ok = (c == "0") || (c == "1");
                            else
                                ok = (c >= "0") && (c <= "7");
                            if (!ok)
                                rad_next[2] = 1'b1;
                        end
                        len_next = grow(len_reg);
                    end
                    else
                    begin
                        g.count = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_OPER, M_SLASH:
                begin
                    if (mode_reg == M_SLASH && c == "/")
                        mode_next = M_LCOM;
                    else if (mode_reg == M_SLASH && c == "*")
                        mode_next = M_BCOM;
                    else if (cstok_pkg::is_op(c) && c != "!" && c != "%" && c != "^"
                             && c != "*")
                    begin
                        len_next = grow(len_reg);
                        g.count  = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        g.count = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_STR, M_CHR:
                begin
                    if (c == 8'h0A)
                    begin
                        lines_next = (lines_reg < cstok_pkg::LineTop) ? lines_reg + 24'd1
                                                                   : lines_reg;
                        g.count = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if ((mode_reg == M_STR && c == "\"")
                             || (mode_reg == M_CHR && c == "'"))
                    begin
                        len_next = grow(len_reg);
                        g.count = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                        len_next = grow(len_reg);
                end
                M_HASH, M_LCOM:
                begin
                    if (c == 8'h0A)
                    begin
                        mode_next = M_IDLE;
                        redo = 1'b1;
                    end
                end
                M_BCOM:
                begin
                    if (c == "*")
                        mode_next = M_BSTAR;
                    else if (c == 8'h0A)
                        lines_next = (lines_reg < cstok_pkg::LineTop) ? lines_reg + 24'd1
                                                                   : lines_reg;
                end
                M_BSTAR:
                begin
                    if (c == "/")
                        mode_next = M_IDLE;
                    else if (c != "*")
                    begin
                        mode_next = M_BCOM;
                        if (c == 8'h0A)
                            lines_next = (lines_reg < cstok_pkg::LineTop)
                                       ? lines_reg + 24'd1 : lines_reg;
                    end
                end
                default: redo = 1'b1;
            endcase

            // result of the token just closed
            r.start_offset  = start_reg;
            r.line_number   = cur_ln;
            r.lexeme_length = len_next;
            if (mode_reg == M_STR || mode_reg == M_CHR)
            begin
                if (c == 8'h0A)
                begin
                    r.token_kind = cstok_pkg::K_DIAG;
                    r.diagnostic = (mode_reg == M_STR) ? cstok_pkg::D_NO_DQ
                                                       : cstok_pkg::D_NO_SQ;
                end
                else if (mode_reg == M_STR || len_next == 8'd3)
                    r.token_kind = cstok_pkg::K_CONST;
                else
                    r.token_kind = cstok_pkg::K_UNKNOWN;
            end
            else if (mode_reg == M_OPER || mode_reg == M_SLASH)
                r.token_kind = cstok_pkg::K_OPER;
        end
        else
        begin
            if (mode_reg == M_OPER || mode_reg == M_SLASH)
                r.token_kind = cstok_pkg::K_OPER;
            else if (mode_reg == M_STR || mode_reg == M_CHR)
            begin
                r.token_kind = cstok_pkg::K_DIAG;
                r.diagnostic = (mode_reg == M_STR) ? cstok_pkg::D_NO_DQ
                                                   : cstok_pkg::D_NO_SQ;
            end
        end

        if (mode_reg == M_WORD)
        begin
            for (int i = cstok_pkg::KeywordCount - 1; i >= 0; i--)
            begin
                if (alive_reg[i] && {4'd0, cstok_pkg::kw_len(5'(i))} == len_reg)
                begin
                    hit = 1'b1;
                    r.keyword_index = 5'(i);
                end
            end
            r.lexeme_length = len_reg;
            if (hit)
                r.token_kind = cstok_pkg::K_KEYWORD;
            else if (rad_reg[4])
                r.token_kind = cstok_pkg::K_IDENT;
            else if (!num_reg[0])
                r.token_kind = cstok_pkg::K_CONST;
            else
                r.token_kind = cstok_pkg::K_UNKNOWN;
        end
        else if (mode_reg == M_ZERO)
        begin
            r.lexeme_length = len_reg;
            if (rad_reg[2])
            begin
                r.token_kind = cstok_pkg::K_DIAG;
                r.diagnostic = cstok_pkg::D_RADIX + {2'd0, rad_reg[1:0]};
            end
            else
                r.token_kind = cstok_pkg::K_CONST;
        end
        if (!in_end && (mode_reg == M_OPER || mode_reg == M_SLASH) && !redo)
            r.lexeme_length = len_next;
        if (!in_end && (mode_reg == M_OPER || mode_reg == M_SLASH) && redo)
            r.lexeme_length = len_reg;
        g.r0 = r;

        // second stage: the byte dispatched afresh
        if (redo)
        begin
            mode_next = M_IDLE;
            if (c == "#")
                mode_next = M_HASH;
            else if (c == "/")
            begin
                mode_next = M_SLASH;
                start_next = off_reg;
                len_next = 8'd1;
            end
            else if (cstok_pkg::is_op(c))
            begin
                mode_next = M_OPER;
                start_next = off_reg;
                len_next = 8'd1;
            end
            else if (cstok_pkg::is_special(c))
            begin
                if (c == "{") brc_next = bal(brc_reg, 1'b1);
                if (c == "}") brc_next = bal(brc_reg, 1'b0);
                if (c == "(") par_next = bal(par_reg, 1'b1);
                if (c == ")") par_next = bal(par_reg, 1'b0);
                r = '0;
                r.token_kind = cstok_pkg::K_SPECIAL;
                r.start_offset = off_reg;
                r.lexeme_length = 8'd1;
                r.line_number = cur_ln;
                if (g.count == 2'd0) g.r0 = r; else g.r1 = r;
                g.count = g.count + 2'd1;
            end
            else if (c == "\"")
            begin
                mode_next = M_STR;
                start_next = off_reg;
                len_next = 8'd1;
            end
            else if (c == "0")
            begin
                mode_next = M_ZERO;
                start_next = off_reg;
                len_next = 8'd1;
                rad_next = 5'd0;
            end
            else if (cstok_pkg::is_digit(c) || cstok_pkg::is_letter(c) || c == "_")
            begin
                mode_next = M_WORD;
                start_next = off_reg;
                len_next = 8'd1;
                rad_next = cstok_pkg::is_digit(c) ? 5'd0 : 5'd16;
                for (int i = 0; i < cstok_pkg::KeywordCount; i++)
                    alive_next[i] = (cstok_pkg::kw_at(5'(i), 8'd0) == c);
                num_next = (cstok_pkg::is_digit(c)) ? 3'd0 : 3'd1;
            end
            else if (c == "'")
            begin
                mode_next = M_CHR;
                start_next = off_reg;
                len_next = 8'd1;
            end
            else if (c == 8'h0A)
            begin
                ln_used = cur_ln;
                lines_next = (lines_reg < cstok_pkg::LineTop) ? lines_reg + 24'd1
                                                           : lines_reg;
                if (par_reg != 16'sd0)
                begin
                    r = '0;
                    r.token_kind = cstok_pkg::K_DIAG;
                    r.diagnostic = (par_reg > 16'sd0) ? cstok_pkg::D_NO_RPAR
                                                      : cstok_pkg::D_NO_LPAR;
                    r.start_offset = off_reg;
                    r.line_number = ln_used;
                    if (g.count == 2'd0) g.r0 = r; else g.r1 = r;
                    g.count = g.count + 2'd1;
                end
            end
        end

        // end of text: brace check and end mark
        if (in_end)
        begin
            mode_next = M_IDLE;
            r = '0;
            r.start_offset = off_reg;
            r.line_number = cur_ln;
            if (brc_reg != 16'sd0)
            begin
                r.token_kind = cstok_pkg::K_DIAG;
                r.diagnostic = (brc_reg > 16'sd0) ? cstok_pkg::D_NO_RBRC
                                                  : cstok_pkg::D_NO_LBRC;
                if (g.count == 2'd0) g.r0 = r; else g.r1 = r;
                g.count = g.count + 2'd1;
            end
            r.token_kind = cstok_pkg::K_END;
            r.diagnostic = cstok_pkg::D_NONE;
            case (g.count)
                2'd0: g.r0 = r;
                2'd1: g.r1 = r;
                default: g.r2 = r;
            endcase
            g.count = g.count + 2'd1;
        end
    end

    assign grp = g;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            len_reg   <= '0;
            alive_reg <= '1;
            num_reg   <= '0;
            rad_reg   <= '0;
            start_reg <= '0;
            off_reg   <= '0;
            lines_reg <= '0;
            par_reg   <= '0;
            brc_reg   <= '0;
        end
        else if (in_go)
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            alive_reg <= alive_next;
            num_reg   <= num_next;
            rad_reg   <= rad_next;
            start_reg <= start_next;
            lines_reg <= lines_next;
            par_reg   <= par_next;
            brc_reg   <= brc_next;
            if (!in_end)
                off_reg <= off_reg + 32'd1;
        end
    end

    `ASSERT_ALWAYS(a_par_range, clk, rst_n, par_reg >= -cstok_pkg::BalTop)
    `ASSERT_IMPL(a_end_emits, clk, rst_n, in_go && in_end, grp.count != 2'd0)
    `ASSERT_IMPL(a_len_nonzero, clk, rst_n, mode_reg == M_WORD, len_reg != 8'd0)
endmodule
`default_nettype wire

### rtl/core/cstok_queue.sv
// Result queue between front end and output: four entries of result groups.
// Depends on cstok_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cstok_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cstok_pkg::group_t push_grp,
    output logic                   room,
    output logic                   has,
    output cstok_pkg::group_t      head,
    input  wire logic              pop
);
    cstok_pkg::group_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign room = (cnt_reg < 3'd3) || ((cnt_reg == 3'd3) && 1'b1);
    assign has  = (cnt_reg != 3'd0);
    assign head = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && cnt_reg != 3'd4)
            mem_reg[wp_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    `ASSERT_IMPL(a_no_overflow, clk, rst_n, push, cnt_reg != 3'd4 || pop)
    `ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, cnt_reg != 3'd0)
endmodule
`default_nettype wire

### rtl/core/cstok_back.sv
// Back end: walks the results of a queued group onto the output stream.
// Depends on cstok_pkg.
`default_nettype none
module cstok_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              has,
    input  wire cstok_pkg::group_t head,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [75:0]            m_tdata,
    output logic                   m_tlast
);
    logic [1:0] idx_reg;
    cstok_pkg::result_t r;

    always_comb
    begin
        case (idx_reg)
            2'd0: r = head.r0;
            2'd1: r = head.r1;
            default: r = head.r2;
        endcase
    end

    assign m_tvalid = has;
    assign m_tlast  = (idx_reg + 2'd1 == head.count);
    assign m_tdata  = {r.lexeme_length, r.start_offset, r.line_number, r.diagnostic,
                       r.keyword_index, r.token_kind};
    assign pop = has && m_tready && m_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (has && m_tready)
            idx_reg <= m_tlast ? 2'd0 : idx_reg + 2'd1;
    end
endmodule
`default_nettype wire

### rtl/core/c_source_byte_tokenizer.sv
// C source byte tokenizer, top level: front end, result queue, output stage.
// Latency: with the queue empty, a byte's first result is offered the cycle after its transaction.
// Throughput: 1 byte/cycle if s_tready; 1 result/cycle if m_tready; up to 3 results per byte.
// The four-entry result queue decouples input from output back-pressure.
// Reset (rst_n, asynchronous, active low) clears lexer state, counters and queue.
// Depends on cstok_pkg, cstok_front, cstok_queue, cstok_back.
`default_nettype none
module c_source_byte_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_value
    input  wire logic        s_tuser,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // token_kind[2:0], keyword_index[7:3], diagnostic[11:8], line_number[35:12],
    // start_offset[67:36], lexeme_length[75:68]
    output logic [79:0]      m_tdata,
    output logic             m_tlast
);
    cstok_pkg::group_t grp, head;
    logic go, room, has, pop;
    logic [75:0] d;

    // transaction on the input side only when a queue slot is free
    assign s_tready = room;
    assign go = s_tvalid && s_tready;

    cstok_front u_front (
        .clk(clk), .rst_n(rst_n), .in_go(go), .in_byte(s_tdata), .in_end(s_tuser),
        .grp(grp)
    );

    // empty groups carry no result and are not queued
    cstok_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(go && grp.count != 2'd0), .push_grp(grp),
        .room(room), .has(has), .head(head), .pop(pop)
    );

    cstok_back u_back (
        .clk(clk), .rst_n(rst_n), .has(has), .head(head), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(d), .m_tlast(m_tlast)
    );

    assign m_tdata = {4'd0, d};
endmodule
`default_nettype wire
